>>> rtl/double_ended_queue_defines.svh
// Assertion macros shared by the double-ended queue RTL.
// Included by the controller and datapath; no other dependencies.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH
`ifndef SYNTHESIS
`define DEQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DEQ_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define DEQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define DEQ_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

>>> rtl/deq_pkg.sv
// Shared types and constants for the double-ended queue.
// No dependencies; used by the top level, controller and datapath (not by deq_ram).
`default_nettype none
package deq_pkg;

  localparam int IO_DATA_W = 32;   // data_in / data_out width on the ports
  localparam int FILL_W    = 5;    // fill_count width on the port
  localparam int ACT_W     = 2;
  localparam int S_TDATA_W = 32;
  localparam int S_TUSER_W = ACT_W;
  localparam int M_TDATA_W = 40;   // data_out + fill_count, byte padded
  localparam int M_TUSER_W = 2;    // was_empty, push_dropped
  localparam int M_PAD_W   = M_TDATA_W - IO_DATA_W - FILL_W;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_BACK  = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_BACK   = 2'd3
  } act_e;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // latch the incoming request
    logic exec;     // perform the action: pointer/count update, RAM access
    logic load;     // move the result into the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_stall;  // output register full and not being taken
  } sts_t;

endpackage
`default_nettype wire

>>> rtl/double_ended_queue.sv
// Top level of the double-ended queue: ring buffer of words, push/pop at both ends.
// Depends on deq_pkg, deq_ctrl, deq_dp (which holds deq_ram).
//
//   channel | direction | tdata                            | tuser
//   s_axis  | in        | [31:0] data_in                   | [1:0] action
//   m_axis  | out       | [31:0] data_out, [36:32] fill    | [0] was_empty, [1] push_dropped
//
// Each request passes through accept, execute (one port of the slot RAM,
// write for a push, read for a pop), then load of the output register.
// The registered RAM read sets the execute-to-result step.
// Reset clears pointer, count and handshakes; slots are left unset, no clearing pass.
// A result waiting in the output register stalls only the result load of the next request.
`default_nettype none
module double_ended_queue #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [deq_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // [31:0] data_in
  input  wire logic [deq_pkg::S_TUSER_W-1:0]   s_axis_tuser,  // [1:0] action
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic      [deq_pkg::M_TDATA_W-1:0]   m_axis_tdata,  // [31:0] data_out, [36:32] fill_count
  output logic      [deq_pkg::M_TUSER_W-1:0]   m_axis_tuser   // [0] was_empty, [1] push_dropped
);
  import deq_pkg::*;

  cmd_t cmd;
  sts_t sts;
  act_e action;

  assign action = act_e'(s_axis_tuser);

  deq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  deq_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .action_i   (action),
    .data_in_i  (s_axis_tdata[IO_DATA_W-1:0]),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser)
  );

endmodule
`default_nettype wire

>>> rtl/deq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> rtl/deq_ctrl.sv
// Sequencing controller of the double-ended queue: idle, execute, result.
// Depends on deq_pkg and double_ended_queue_defines.svh.
`default_nettype none
`include "double_ended_queue_defines.svh"
module deq_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_tvalid_i,
  output logic               s_tready_o,
  input  wire deq_pkg::sts_t sts_i,
  output deq_pkg::cmd_t      cmd_o
);
  import deq_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_EXEC   = 3'b010,
    ST_RESULT = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (!sts_i.out_stall) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign s_tready_o    = (state_q == ST_IDLE);
  assign cmd_o.capture = (state_q == ST_IDLE) && s_tvalid_i;
  assign cmd_o.exec    = (state_q == ST_EXEC);
  assign cmd_o.load    = (state_q == ST_RESULT) && !sts_i.out_stall;

  `DEQ_ASSERT(a_accept_then_exec, clk_i, rst_ni, (s_tvalid_i && s_tready_o) |=> (state_q == ST_EXEC), "accepted request not executed")
  `DEQ_ASSERT(a_exec_then_result, clk_i, rst_ni, (state_q == ST_EXEC) |=> (state_q == ST_RESULT), "execute not followed by result")
  `DEQ_ASSERT(a_load_then_idle, clk_i, rst_ni, cmd_o.load |=> s_tready_o, "not ready after result load")

endmodule
`default_nettype wire

>>> rtl/deq_dp.sv
// Datapath of the double-ended queue: pointers, count, slot RAM, output register.
// Depends on deq_pkg, deq_ram and double_ended_queue_defines.svh.
`default_nettype none
`include "double_ended_queue_defines.svh"
module deq_dp #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire deq_pkg::cmd_t                     cmd_i,
  output deq_pkg::sts_t                          sts_o,
  input  wire deq_pkg::act_e                     action_i,
  input  wire logic [deq_pkg::IO_DATA_W-1:0]     data_in_i,
  input  wire logic                              m_tready_i,
  output logic                                   m_tvalid_o,
  output logic      [deq_pkg::M_TDATA_W-1:0]     m_tdata_o,
  output logic      [deq_pkg::M_TUSER_W-1:0]     m_tuser_o
);
  import deq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  // request latched at accept
  act_e                 act_q;
  logic [IO_DATA_W-1:0] word_q;

  logic [AW-1:0] front_q, front_d;
  logic [CW-1:0] count_q, count_d;
  logic          empty_q, empty_d;
  logic          drop_q, drop_d;
  logic          pop_ok_q, pop_ok_d;

  logic                  out_valid_q, out_valid_d;
  logic [IO_DATA_W-1:0]  out_data_q;
  logic [FILL_W-1:0]     out_fill_q;
  logic                  out_empty_q, out_drop_q;

  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

  logic          full, empty;
  logic [AW-1:0] front_dec, front_inc, back_pos, last_pos;
  logic [SW-1:0] sum_back, sum_last;

  assign full  = (count_q == CW'(DEPTH));
  assign empty = (count_q == '0);

  assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
  assign front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + AW'(1);

  // front + count stays below 2*DEPTH, and so does front + count - 1 when count is nonzero
  assign sum_back = SW'(front_q) + SW'(count_q);
  assign sum_last = sum_back - SW'(1);
  assign back_pos = (sum_back >= SW'(DEPTH)) ? AW'(sum_back - SW'(DEPTH)) : AW'(sum_back);
  assign last_pos = (sum_last >= SW'(DEPTH)) ? AW'(sum_last - SW'(DEPTH)) : AW'(sum_last);

  assign ram_wdata = DATA_WIDTH'(word_q);

  always_comb begin
    front_d   = front_q;
    count_d   = count_q;
    empty_d   = empty_q;
    drop_d    = drop_q;
    pop_ok_d  = pop_ok_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = front_q;
    ram_raddr = front_q;
    if (cmd_i.exec) begin
      empty_d  = 1'b0;
      drop_d   = 1'b0;
      pop_ok_d = 1'b0;
      case (act_q)
        ACT_PUSH_FRONT: begin
          if (full) begin
            drop_d = 1'b1;
          end else begin
            front_d   = front_dec;
            ram_we    = 1'b1;
            ram_waddr = front_dec;
            count_d   = count_q + CW'(1);
          end
        end
        ACT_PUSH_BACK: begin
          if (full) begin
            drop_d = 1'b1;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = back_pos;
            count_d   = count_q + CW'(1);
          end
        end
        ACT_POP_FRONT: begin
          if (empty) begin
            empty_d = 1'b1;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = front_q;
            front_d   = front_inc;
            count_d   = count_q - CW'(1);
            pop_ok_d  = 1'b1;
          end
        end
        default: begin
          if (empty) begin
            empty_d = 1'b1;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = last_pos;
            count_d   = count_q - CW'(1);
            pop_ok_d  = 1'b1;
          end
        end
      endcase
    end
  end

  deq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      count_q     <= '0;
      empty_q     <= 1'b0;
      drop_q      <= 1'b0;
      pop_ok_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      front_q     <= front_d;
      count_q     <= count_d;
      empty_q     <= empty_d;
      drop_q      <= drop_d;
      pop_ok_q    <= pop_ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q  <= action_i;
      word_q <= data_in_i;
    end
    if (cmd_i.load) begin
      out_data_q  <= pop_ok_q ? IO_DATA_W'(ram_rdata) : '0;
      out_fill_q  <= FILL_W'(count_q);
      out_empty_q <= empty_q;
      out_drop_q  <= drop_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign sts_o.out_stall = out_valid_q && !m_tready_i;
  assign m_tvalid_o      = out_valid_q;
  assign m_tdata_o       = {{M_PAD_W{1'b0}}, out_fill_q, out_data_q};
  assign m_tuser_o       = {out_drop_q, out_empty_q};

  `DEQ_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CW'(DEPTH), "count above depth")
  `DEQ_ASSERT_NEVER(a_no_rw_same_cycle, clk_i, rst_ni, ram_we && ram_re, "slot read and write together")
  `DEQ_ASSERT_NEVER(a_load_no_overwrite, clk_i, rst_ni, cmd_i.load && out_valid_q && !m_tready_i, "result overwritten")
  `DEQ_ASSERT(a_front_only_on_exec, clk_i, rst_ni, !cmd_i.exec |=> $stable(front_q), "front moved outside execute")

endmodule
`default_nettype wire

>>> tb/sv/tb_double_ended_queue.sv
// Self-checking testbench for double_ended_queue: it drives requests on s_axis,
// predicts each result with a ring-buffer model and checks m_axis against it.
// Depends on deq_pkg and the double_ended_queue RTL.
module tb_double_ended_queue;
  import deq_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam int DATA_W      = 32;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic [DATA_W-1:0] data;
    logic              was_empty;
    logic              push_dropped;
    logic [4:0]        fill;
  } deq_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;  // [31:0] data_in
  logic [S_TUSER_W-1:0] s_axis_tuser  = '0;  // [1:0] action
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;        // [31:0] data_out, [36:32] fill_count
  logic [M_TUSER_W-1:0] m_axis_tuser;        // [0] was_empty, [1] push_dropped

  double_ended_queue #(
    .DEPTH      (QUEUE_DEPTH),
    .DATA_WIDTH (DATA_W)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  // Ring-buffer prediction state
  logic [DATA_W-1:0] slot_mem [QUEUE_DEPTH];
  logic [3:0]        head_idx = '0;
  logic [4:0]        held     = '0;
  deq_result_t       pending_results [$];

  int error_count    = 0;
  int requests_sent  = 0;
  int results_seen   = 0;
  int empty_pops     = 0;
  int dropped_pushes = 0;
  int peak_fill      = 0;
  int input_stalls   = 0;
  int cycle_count    = 0;

  // Receiver controls
  int stall_pct  = 0;
  int stall_left = 0;
  int hold_left  = 0;

  function automatic deq_result_t apply_deque_action(act_e act, logic [DATA_W-1:0] word);
    deq_result_t r;
    logic [3:0]  pos;
    r = '{data: '0, was_empty: 1'b0, push_dropped: 1'b0, fill: '0};
    case (act)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (held == QUEUE_DEPTH) begin
          r.push_dropped = 1'b1;
          dropped_pushes++;
        end else begin
          if (act == ACT_PUSH_FRONT) begin
            head_idx = head_idx - 4'd1;
            pos = head_idx;
          end else begin
            pos = head_idx + held[3:0];
          end
          slot_mem[pos] = word;
          held++;
        end
      end
      default: begin
        if (held == 0) begin
          r.was_empty = 1'b1;
          empty_pops++;
        end else if (act == ACT_POP_FRONT) begin
          r.data   = slot_mem[head_idx];
          head_idx = head_idx + 4'd1;
          held--;
        end else begin
          // held[3:0] is 0 when full, so the minus one still lands on the last slot
          pos    = head_idx + held[3:0] - 4'd1;
          r.data = slot_mem[pos];
          held--;
        end
      end
    endcase
    r.fill = held;
    if (held > peak_fill) peak_fill = held;
    return r;
  endfunction

  task automatic offer_request(input act_e act, input logic [DATA_W-1:0] word);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= word;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(apply_deque_action(act, word));
    requests_sent++;
  endtask

  task automatic pause_sender(input int cycles);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  function automatic logic [DATA_W-1:0] random_word();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic act_e random_action(int push_pct);
    if ($urandom_range(99) < push_pct)
      return $urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
    return $urandom_range(1) ? ACT_POP_BACK : ACT_POP_FRONT;
  endfunction

  task automatic compare_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  // Result checker
  always @(posedge clk_i) begin
    deq_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: tdata 0x%0h tuser 0x%0h",
               m_axis_tdata, m_axis_tuser);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        compare_field("data_out", want.data, m_axis_tdata[31:0]);
        compare_field("fill_count", DATA_W'(want.fill), DATA_W'(m_axis_tdata[36:32]));
        compare_field("was_empty", DATA_W'(want.was_empty), DATA_W'(m_axis_tuser[0]));
        compare_field("push_dropped", DATA_W'(want.push_dropped), DATA_W'(m_axis_tuser[1]));
      end
    end
  end

  // Receiver: short random stalls, plus an optional long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(99) < stall_pct) begin
      stall_left = $urandom_range(3);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (rst_ni && s_axis_tvalid && !s_axis_tready) input_stalls++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic test_empty_pop();
    offer_request(ACT_POP_BACK, '1);
  endtask

  task automatic test_both_ends();
    offer_request(ACT_PUSH_BACK, 32'hFFFF_FFFF);
    offer_request(ACT_PUSH_FRONT, 32'h0000_0000);
    offer_request(ACT_POP_BACK, 32'h1234_5678);
    offer_request(ACT_POP_FRONT, 32'h0);
    // queue is empty again here; front pop must report it
    offer_request(ACT_POP_FRONT, 32'hA5A5_A5A5);
  endtask

  task automatic test_backpressure();
    int i;
    stall_pct = 0;
    hold_left = 80;
    for (i = 0; i < 10; i++)
      offer_request(i[0] ? ACT_PUSH_FRONT : ACT_PUSH_BACK, random_word());
    for (i = 0; i < 10; i++)
      offer_request(i[0] ? ACT_POP_BACK : ACT_POP_FRONT, random_word());
  endtask

  task automatic test_full_queue();
    int i;
    stall_pct = 20;
    for (i = 0; i < QUEUE_DEPTH; i++)
      offer_request(i[1] ? ACT_PUSH_FRONT : ACT_PUSH_BACK, random_word());
    offer_request(ACT_PUSH_FRONT, 32'h5A5A_5A5A);
    offer_request(ACT_PUSH_BACK, 32'hA5A5_A5A5);
  endtask

  task automatic test_random_mix();
    int seg;
    int i;
    int push_pct;
    int burst_left;
    bit gaps_on;
    burst_left = $urandom_range(1, 12);
    for (seg = 0; seg < 14; seg++) begin
      // pick a filling, draining or balanced stretch at random
      case ($urandom_range(2))
        0:       push_pct = 15;
        1:       push_pct = 50;
        default: push_pct = 85;
      endcase
      case (seg % 3)
        0:       stall_pct = 0;
        1:       stall_pct = 25;
        default: stall_pct = 60;
      endcase
      gaps_on = (seg % 4) != 0;
      for (i = 0; i < 50; i++) begin
        offer_request(random_action(push_pct), random_word());
        burst_left--;
        if (burst_left == 0) begin
          if (gaps_on) pause_sender($urandom_range(1, 6));
          burst_left = $urandom_range(1, 12);
        end
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_pop();
    test_both_ends();
    test_backpressure();
    test_full_queue();
    test_random_mix();
    pause_sender(1);

    stall_pct = 10;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Covered %0d requests, %0d results; %0d empty pops, %0d dropped pushes",
             requests_sent, results_seen, empty_pops, dropped_pushes);
    $display("Peak fill %0d of %0d, %0d cycles with the input held off",
             peak_fill, QUEUE_DEPTH, input_stalls);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> double_ended_queue.f
+incdir+rtl
rtl/deq_pkg.sv
rtl/deq_ram.sv
rtl/deq_ctrl.sv
rtl/deq_dp.sv
rtl/double_ended_queue.sv
tb/sv/tb_double_ended_queue.sv
